### rtl/core/mns_pkg.sv
package mns_pkg;

	// score table geometry
	localparam int SCORE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(SCORE_DEPTH);

	// field widths
	localparam int CMD_W        = 3;
	localparam int INDEX_W      = 6;
	localparam int PERIOD_W     = 8;
	localparam int DURATION_W   = 8;
	localparam int NOTE_POS_W   = 6;
	localparam int SCORE_LEN_W  = 7;
	localparam int REST_W       = 8;
	localparam int ENTRY_W      = PERIOD_W + DURATION_W;
	localparam int CFG_DATA_W   = 8;
	localparam int CFG_INDEX_W  = 1;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_NOTE_COUNT = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_REST_TICKS = 1'b1;

	// reset values of the configuration registers
	localparam logic [SCORE_LEN_W-1:0] SCORE_LEN_RESET  = '0;
	localparam logic [REST_W-1:0]      REST_TICKS_RESET = REST_W'(1);

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_BEAT  = 3'd0,
		CMD_TONE  = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_START = 3'd3,
		CMD_STOP  = 3'd4,
		CMD_CLEAR = 3'd5
	} cmd_t;

	// one input word as held in the input stage
	typedef struct packed {
		cmd_t                  command;
		logic [INDEX_W-1:0]    entry_index;
		logic [PERIOD_W-1:0]   entry_period;
		logic [DURATION_W-1:0] entry_duration;
	} item_t;

	// one result word
	typedef struct packed {
		logic                  pin_level;
		logic                  playing;
		logic [NOTE_POS_W-1:0] note_position;
		logic [PERIOD_W-1:0]   tone_period_now;
		logic                  resting;
	} result_t;

	// configuration seen by the sequencer core
	typedef struct packed {
		logic [SCORE_LEN_W-1:0] note_count;
		logic [REST_W-1:0]      rest_ticks;
	} cfg_t;

endpackage

### rtl/core/mns_in_if.sv
interface mns_in_if
	import mns_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      command;
	logic [INDEX_W-1:0]    entry_index;
	logic [PERIOD_W-1:0]   entry_period;
	logic [DURATION_W-1:0] entry_duration;

	modport source (
		output valid, command, entry_index, entry_period, entry_duration,
		input  ready
	);

	modport sink (
		input  valid, command, entry_index, entry_period, entry_duration,
		output ready
	);
endinterface

### rtl/core/mns_out_if.sv
interface mns_out_if
	import mns_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic                  pin_level;
	logic                  playing;
	logic [NOTE_POS_W-1:0] note_position;
	logic [PERIOD_W-1:0]   tone_period_now;
	logic                  resting;

	modport source (
		output valid, pin_level, playing, note_position, tone_period_now, resting,
		input  ready
	);

	modport sink (
		input  valid, pin_level, playing, note_position, tone_period_now, resting,
		output ready
	);
endinterface

### rtl/core/melody_note_sequencer.sv
// an accepted word is held in the input stage, then its result is registered at the output
// throughput: one word per cycle unless result.ready stalls; core state updates per word
// the score table is read at the position of the next word, so no stall is needed
// reset: arst_n clears playback state, handshakes and sets rest_ticks to 1
// score table entries are undefined after reset until written; no clearing pass
module melody_note_sequencer
	import mns_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	mns_in_if.sink                 item,
	mns_out_if.source              result
);
	cfg_t    cfg_q;
	logic    v_s1;
	item_t   item_s1;
	logic    adv;
	result_t res;
	logic    out_v_q;
	result_t out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.note_count <= SCORE_LEN_RESET;
			cfg_q.rest_ticks <= REST_TICKS_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_NOTE_COUNT: cfg_q.note_count <= cfg_data[SCORE_LEN_W-1:0];
				REG_REST_TICKS: cfg_q.rest_ticks <= cfg_data[REST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input stage moves on whenever the output register is free or drained
	assign adv        = v_s1 && (!out_v_q || result.ready);
	assign item.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.command        <= cmd_t'(item.command);
			item_s1.entry_index    <= item.entry_index;
			item_s1.entry_period   <= item.entry_period;
			item_s1.entry_duration <= item.entry_duration;
		end
	end

	// sequencer state and score table
	mns_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign result.valid           = out_v_q;
	assign result.pin_level       = out_q.pin_level;
	assign result.playing         = out_q.playing;
	assign result.note_position   = out_q.note_position;
	assign result.tone_period_now = out_q.tone_period_now;
	assign result.resting         = out_q.resting;
endmodule

### rtl/core/mns_ram.sv
module mns_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

### rtl/core/mns_core.sv
module mns_core
	import mns_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);
	// playback state
	logic [ADDR_W-1:0]   pos_q, pos_d;
	logic [REST_W-1:0]   beat_q, beat_d;
	logic                rest_q, rest_d;
	logic                run_q, run_d;
	logic [PERIOD_W-1:0] act_q, act_d;
	logic [PERIOD_W-1:0] tone_q, tone_d;
	logic                pin_q, pin_d;

	// copy of entry 0's period for start
	logic [PERIOD_W-1:0] per0_q;

	// write-to-read bypass for the current entry
	logic               byp_q;
	logic [ENTRY_W-1:0] byp_data_q;

	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [ENTRY_W-1:0]    wr_data;
	logic [ENTRY_W-1:0]    ram_rdata;
	logic [ENTRY_W-1:0]    cur_entry;
	logic [PERIOD_W-1:0]   cur_period;
	logic [DURATION_W-1:0] cur_dur;
	logic [ADDR_W:0]       pos_inc;
	logic                  limit_hit;
	logic [PERIOD_W-1:0]   tone_inc;

	// score table write
	assign wr_en   = step && (item.command == CMD_WRITE) && (32'(item.entry_index) < SCORE_DEPTH);
	assign wr_addr = ADDR_W'(item.entry_index);
	assign wr_data = {item.entry_period, item.entry_duration};

	// score table, read at the position the next word will see
	mns_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SCORE_DEPTH)
	) u_score_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (pos_d),
		.rdata (ram_rdata)
	);

	// current entry, with a fresh write to the same entry forwarded
	assign cur_entry  = byp_q ? byp_data_q : ram_rdata;
	assign cur_period = cur_entry[ENTRY_W-1:DURATION_W];
	assign cur_dur    = cur_entry[DURATION_W-1:0];

	// end of score check
	assign pos_inc   = {1'b0, pos_q} + (ADDR_W+1)'(1);
	assign limit_hit = (32'(pos_inc) >= 32'(cfg.note_count)) || (32'(pos_inc) >= SCORE_DEPTH);
	assign tone_inc  = tone_q + PERIOD_W'(1);

	// next state
	always_comb begin
		pos_d  = pos_q;
		beat_d = beat_q;
		rest_d = rest_q;
		run_d  = run_q;
		act_d  = act_q;
		tone_d = tone_q;
		pin_d  = pin_q;
		if (step) begin
			case (item.command)
				CMD_BEAT: begin
					if (run_q) begin
						if (rest_q) begin
							if (beat_q >= cfg.rest_ticks) begin
								act_d  = cur_period;
								rest_d = 1'b0;
								beat_d = '0;
							end else begin
								beat_d = beat_q + REST_W'(1);
							end
						end else if (beat_q >= cur_dur) begin
							if (limit_hit) begin
								pos_d = '0;
								run_d = 1'b0;
							end else begin
								pos_d = pos_inc[ADDR_W-1:0];
							end
							act_d  = '0;
							rest_d = 1'b1;
							beat_d = '0;
						end else begin
							beat_d = beat_q + REST_W'(1);
						end
					end
				end
				CMD_TONE: begin
					if (run_q) begin
						if (act_q == '0) begin
							tone_d = '0;
						end else if (tone_inc >= act_q) begin
							pin_d  = ~pin_q;
							tone_d = '0;
						end else begin
							tone_d = tone_inc;
						end
					end
				end
				CMD_START: begin
					run_d  = 1'b1;
					act_d  = per0_q;
					tone_d = '0;
				end
				CMD_STOP: begin
					run_d = 1'b0;
				end
				CMD_CLEAR: begin
					pos_d  = '0;
					beat_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			beat_q <= '0;
			rest_q <= 1'b0;
			run_q  <= 1'b0;
			act_q  <= '0;
			tone_q <= '0;
			pin_q  <= 1'b0;
			byp_q  <= 1'b0;
		end else begin
			pos_q  <= pos_d;
			beat_q <= beat_d;
			rest_q <= rest_d;
			run_q  <= run_d;
			act_q  <= act_d;
			tone_q <= tone_d;
			pin_q  <= pin_d;
			byp_q  <= wr_en && (wr_addr == pos_d);
		end
	end

	// bypass data and entry 0 copy
	always_ff @(posedge clk) begin
		byp_data_q <= wr_data;
		if (wr_en && (wr_addr == '0)) begin
			per0_q <= item.entry_period;
		end
	end

	// result after this word's update
	always_comb begin
		res.pin_level       = pin_d;
		res.playing         = run_d;
		res.note_position   = NOTE_POS_W'(pos_d);
		res.tone_period_now = act_d;
		res.resting         = rest_d;
	end
endmodule
